// ===== rtl/core/hnpt_pkg.sv =====
package hnpt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 128;
  localparam int PTR_W       = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] SEED_A   = 32'h688B_A2BA;
  localparam logic [31:0] SEED_B   = 32'hF64A_71D5;
  localparam logic [31:0] MISS_PTR = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_APPEND = 2'd1,
    STAT_MISS   = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic        req_type;
    logic        has_char;
    logic [7:0]  char_code;
    logic        name_end;
    logic [31:0] pointer_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pointer_out;
    logic [5:0]  entry_slot;
  } out_item_t;

  // One table request, formed when the symbol name closes.
  typedef struct packed {
    logic             lookup;
    logic [KEY_W-1:0] key;
    logic [PTR_W-1:0] pointer;
  } table_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // One character step of the name hash: returns {a, b}.
  function automatic logic [63:0] hash_step(input logic [31:0] a, input logic [31:0] b,
                                            input logic [7:0] ch);
    logic [31:0] c;
    logic [31:0] a1;
    logic [31:0] b1;
    c  = {{24{ch[7]}}, ch};
    a1 = rotl(a + c, 3);
    b1 = rotl(b ^ c, 7);
    hash_step = {a1 + b1, rotl(b1 + c, 3)};
  endfunction

endpackage

// ===== rtl/core/hnpt_ram.sv =====
module hnpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hnpt_front.sv =====
module hnpt_front
  import hnpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_item_t   item,
  output logic       push_valid,
  input  logic       push_ready,
  output table_req_t push_data
);

  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [63:0] library_key;
  logic        in_symbol;
  logic [63:0] stepped;
  logic [31:0] a_cur;
  logic [31:0] b_cur;
  logic        accept;

  // The queue has room for a request whenever an item is taken.
  assign item_ready = push_ready;
  assign accept     = item_valid && item_ready;

  assign stepped = hash_step(hash_a, hash_b, item.char_code);
  assign a_cur   = item.has_char ? stepped[63:32] : hash_a;
  assign b_cur   = item.has_char ? stepped[31:0]  : hash_b;

  assign push_valid        = accept && item.name_end && in_symbol;
  assign push_data.lookup  = item.req_type;
  assign push_data.key     = {library_key, a_cur, b_cur};
  assign push_data.pointer = item.pointer_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_a      <= SEED_A;
      hash_b      <= SEED_B;
      library_key <= '0;
      in_symbol   <= 1'b0;
    end else if (accept) begin
      if (item.name_end) begin
        hash_a    <= SEED_A;
        hash_b    <= SEED_B;
        in_symbol <= !in_symbol;
        if (!in_symbol) begin
          library_key <= {a_cur, b_cur};
        end
      end else begin
        hash_a <= a_cur;
        hash_b <= b_cur;
      end
    end
  end

endmodule

// ===== rtl/core/hnpt_queue.sv =====
module hnpt_queue
  import hnpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  table_req_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output table_req_t pop_data
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  table_req_t       slots [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = fill != QC_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QC_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QC_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/hnpt_back.sv =====
module hnpt_back
  import hnpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  table_req_t pop_data,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result
);

  back_state_t       state;
  back_state_t       state_next;
  table_req_t        req;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  entry_count;
  logic              cmp_valid;
  logic [SLOT_W-1:0] cmp_idx;
  logic              found;
  logic [SLOT_W-1:0] hit_slot;
  logic [PTR_W-1:0]  hit_ptr;
  logic [KEY_W-1:0]  key_rd;
  logic [PTR_W-1:0]  ptr_rd;
  logic              issue;
  logic              match;
  logic              last_cmp;
  logic              can_out;
  logic              finish;
  logic              table_full;
  logic              ptr_we;
  logic              key_we;
  logic [SLOT_W-1:0] wr_slot;
  out_item_t         res;

  assign table_full = entry_count == CNT_W'(TABLE_DEPTH);
  assign issue      = (state == BK_SEARCH) && (idx < entry_count);
  assign match      = cmp_valid && (key_rd == req.key);
  assign last_cmp   = cmp_valid && ((CNT_W'(cmp_idx) + CNT_W'(1)) == entry_count);
  assign can_out    = !result_valid || result_ready;
  assign finish     = (state == BK_FINISH) && can_out;
  assign wr_slot    = found ? hit_slot : entry_count[SLOT_W-1:0];
  assign ptr_we     = finish && !req.lookup && (found || !table_full);
  assign key_we     = finish && !req.lookup && !found && !table_full;

  hnpt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_slot),
    .wdata (req.key),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (key_rd)
  );

  hnpt_ram #(.WIDTH(PTR_W), .DEPTH(TABLE_DEPTH)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (wr_slot),
    .wdata (req.pointer),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (ptr_rd)
  );

  // Result of the finished search.
  always_comb begin
    res.pointer_out = req.pointer;
    res.entry_slot  = 6'(hit_slot);
    res.status      = STAT_HIT;
    if (req.lookup) begin
      if (found) begin
        res.pointer_out = hit_ptr;
      end else begin
        res.status      = STAT_MISS;
        res.pointer_out = MISS_PTR;
        res.entry_slot  = '0;
      end
    end else if (!found) begin
      if (table_full) begin
        res.status     = STAT_FULL;
        res.entry_slot = '0;
      end else begin
        res.status     = STAT_APPEND;
        res.entry_slot = 6'(entry_count[SLOT_W-1:0]);
      end
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = (entry_count == '0) ? BK_FINISH : BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (match || last_cmp) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (can_out) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      cmp_valid    <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !finish) begin
        result_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          cmp_valid <= 1'b0;
          found     <= 1'b0;
        end
        BK_SEARCH: begin
          cmp_valid <= issue && !match;
          if (match) begin
            found <= 1'b1;
          end
        end
        BK_FINISH: begin
          cmp_valid <= 1'b0;
          if (can_out) begin
            result_valid <= 1'b1;
            if (key_we) begin
              entry_count <= entry_count + CNT_W'(1);
            end
          end
        end
        default: cmp_valid <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop_valid) begin
      req <= pop_data;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
    cmp_idx <= idx[SLOT_W-1:0];
    if (match) begin
      hit_slot <= cmp_idx;
      hit_ptr  <= ptr_rd;
    end
    if (finish) begin
      result <= res;
    end
  end

  // The fill count never runs past the table.
  assert property (@(posedge clk) disable iff (rst) entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // Every compared slot is one that has been written.
  assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (CNT_W'(cmp_idx) < entry_count))
    else $error("compare of an unwritten slot");

  // A finished request always loads the output register.
  assert property (@(posedge clk) disable iff (rst) finish |=> result_valid)
    else $error("finished request produced no result");

  // An append leaves the count one higher.
  assert property (@(posedge clk) disable iff (rst)
    key_we |=> (entry_count == $past(entry_count) + CNT_W'(1)))
    else $error("append did not advance the fill count");

endmodule

// ===== rtl/core/hashed_name_pointer_table.sv =====
// Hashed name pointer table.
// Items arrive on the item channel (item_valid / item_ready / item), one name
// character per transfer: first the library name, then the symbol name, each
// closed by a transfer with name_end set. Characters hash at one per cycle
// while the queue has room. Only the transfer that closes the symbol name
// yields a result, sent on the result channel (result_valid/result_ready/result).
// The front end hashes characters and, on the symbol close, places a key
// request in a two-entry queue. The back end then scans the occupied table
// slots through a registered key memory, one slot per cycle, and writes the
// table on insert. In the back end a request is taken from the queue, its key
// is compared with the occupied slots in turn until a match, and the result
// register is loaded; an empty table skips the compare.
// The result register lets the back end start the next request while a
// result waits; when the receiver stalls, the queue fills and item_ready
// drops only once it holds two requests.
// Reset (rst, synchronous) reseeds the hash, returns to the library name and
// empties the table; the table memories themselves are not cleared.
module hashed_name_pointer_table
  import hnpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  logic       push_valid;
  logic       push_ready;
  table_req_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  table_req_t pop_data;

  // Front end: hashing and name tracking.
  hnpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Request queue between the two halves.
  hnpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: table search, update and result register.
  hnpt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
